// ===== rtl/mlenv_pkg.sv =====
`default_nettype none

package mlenv_pkg;

    localparam int LINES_DEFAULT = 1024;

    localparam int SLOPE_W = 32;
    localparam int ICPT_W  = 48;
    localparam int X_W     = 32;
    localparam int VALUE_W = 64;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    // Hull test operands: intercept and slope differences, and the
    // 25/24-bit split of the intercept difference fed through one multiplier.
    localparam int DI_W    = ICPT_W + 1;
    localparam int DS_W    = SLOPE_W + 1;
    localparam int SPLIT   = 24;
    localparam int MUL_W   = DS_W;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIDE_W  = DI_W + DS_W;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                       cmd;
        logic signed [SLOPE_W-1:0]  slope;
        logic signed [ICPT_W-1:0]   intercept;
        logic signed [X_W-1:0]      x_value;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  min_value;
        logic [STAT_W-1:0]          status;
        logic [COUNT_W-1:0]         line_count;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/monotone_line_envelope_min.sv =====
`default_nettype none

// Lower envelope of lines y = slope*x + intercept, kept as a stack in one
// synchronous line memory of LINES entries (one write port, one read port,
// registered read data). One word in, one word out, one item at a time.
// An add writes the new line, then runs a hull test while at least three
// lines are stacked (two memory reads, four partial products through the
// shared 33x33 multiplier, then the wide compare); each line is popped at
// most once, so the cost of the tests is amortised. A query evaluates the
// line at the pointer and each line above it that it moves on to (one read
// and one multiply each). Empty queries and adds to a full store go
// straight to completion. The next word is taken once the previous one has
// been moved to the output register, even if that result is still held.
// Slopes must arrive non-increasing and query abscissas non-decreasing.
module monotone_line_envelope_min #(
    parameter int LINES = mlenv_pkg::LINES_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire mlenv_pkg::item_t item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output mlenv_pkg::result_t    result
);

    localparam int PW     = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int TW     = $clog2(LINES + 1);
    localparam int LINE_W = mlenv_pkg::SLOPE_W + mlenv_pkg::ICPT_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_CHK = 4'd1;
    localparam logic [3:0] S_ADD_RJ  = 4'd2;
    localparam logic [3:0] S_ADD_RI  = 4'd3;
    localparam logic [3:0] S_ADD_MUL = 4'd4;
    localparam logic [3:0] S_ADD_CMP = 4'd5;
    localparam logic [3:0] S_Q_LOAD  = 4'd6;
    localparam logic [3:0] S_Q_EVAL  = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    // line memory
    logic [LINE_W-1:0] line_mem [LINES];
    logic [LINE_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [LINE_W-1:0] wr_data;
    logic [PW-1:0]     rd_addr;

    logic signed [mlenv_pkg::SLOPE_W-1:0] rd_slope;
    logic signed [mlenv_pkg::ICPT_W-1:0]  rd_icpt;

    // control
    logic [3:0]    state_reg, state_next;
    logic [TW-1:0] top_reg, top_next;
    logic [PW-1:0] qp_reg, qp_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic          first_reg, first_next;
    logic          result_valid_reg, result_valid_next;

    // payload
    logic signed [mlenv_pkg::SLOPE_W-1:0] k_slope_reg, k_slope_next;
    logic signed [mlenv_pkg::ICPT_W-1:0]  k_icpt_reg, k_icpt_next;
    logic signed [mlenv_pkg::SLOPE_W-1:0] j_slope_reg, j_slope_next;
    logic signed [mlenv_pkg::ICPT_W-1:0]  j_icpt_reg, j_icpt_next;
    logic signed [mlenv_pkg::DI_W-1:0]    dik_reg, dik_next;
    logic signed [mlenv_pkg::DI_W-1:0]    dij_reg, dij_next;
    logic signed [mlenv_pkg::DS_W-1:0]    dsij_reg, dsij_next;
    logic signed [mlenv_pkg::DS_W-1:0]    dsik_reg, dsik_next;
    logic signed [mlenv_pkg::WIDE_W-1:0]  lhs_reg, lhs_next;
    logic signed [mlenv_pkg::WIDE_W-1:0]  rhs_reg, rhs_next;
    logic signed [mlenv_pkg::X_W-1:0]     x_reg, x_next;
    logic signed [mlenv_pkg::ICPT_W-1:0]  qicpt_reg, qicpt_next;
    logic signed [mlenv_pkg::VALUE_W-1:0] cur_reg, cur_next;
    logic [mlenv_pkg::STAT_W-1:0]         status_reg, status_next;
    mlenv_pkg::result_t                   result_reg, result_next;

    // shared multiplier
    logic signed [mlenv_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [mlenv_pkg::PROD_W-1:0]  mul_p;
    logic signed [mlenv_pkg::PROD_W-1:0]  prod_reg;

    // scratch
    logic [PW-1:0]                        qp_clamp;
    logic [PW-1:0]                        ptr_now;
    logic [1:0]                           acc_idx;
    logic signed [mlenv_pkg::WIDE_W-1:0]  acc_term;
    logic signed [mlenv_pkg::VALUE_W-1:0] eval_val;
    logic                                 advance;
    logic                                 redundant;

    assign rd_slope     = signed'(rd_data_reg[LINE_W-1:mlenv_pkg::ICPT_W]);
    assign rd_icpt      = signed'(rd_data_reg[mlenv_pkg::ICPT_W-1:0]);
    assign mul_p        = mul_a * mul_b;
    assign redundant    = lhs_reg < rhs_reg;
    assign item_stall   = state_reg != S_IDLE;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        top_next          = top_reg;
        qp_next           = qp_reg;
        cnt_next          = cnt_reg;
        first_next        = first_reg;
        result_valid_next = result_valid_reg;
        k_slope_next      = k_slope_reg;
        k_icpt_next       = k_icpt_reg;
        j_slope_next      = j_slope_reg;
        j_icpt_next       = j_icpt_reg;
        dik_next          = dik_reg;
        dij_next          = dij_reg;
        dsij_next         = dsij_reg;
        dsik_next         = dsik_reg;
        lhs_next          = lhs_reg;
        rhs_next          = rhs_reg;
        x_next            = x_reg;
        qicpt_next        = qicpt_reg;
        cur_next          = cur_reg;
        status_next       = status_reg;
        result_next       = result_reg;

        wr_en    = 1'b0;
        wr_addr  = PW'(top_reg);
        wr_data  = {k_slope_reg, k_icpt_reg};
        rd_addr  = qp_reg;
        mul_a    = mlenv_pkg::MUL_W'(rd_slope);
        mul_b    = mlenv_pkg::MUL_W'(x_reg);

        qp_clamp = (TW'(qp_reg) >= top_reg) ? PW'(top_reg - TW'(1)) : qp_reg;
        acc_idx  = 2'(cnt_reg - 3'd1);
        acc_term = mlenv_pkg::WIDE_W'(prod_reg);
        if (acc_idx[0])
        begin
            acc_term = acc_term <<< mlenv_pkg::SPLIT;
        end
        eval_val = signed'(prod_reg[mlenv_pkg::VALUE_W-1:0])
                   + mlenv_pkg::VALUE_W'(qicpt_reg);
        advance  = !first_reg && (eval_val < cur_reg);
        ptr_now  = advance ? PW'(qp_reg + PW'(1)) : qp_reg;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    status_next = mlenv_pkg::ST_OK;
                    cur_next    = '0;
                    if (item.cmd == mlenv_pkg::CMD_ADD)
                    begin
                        if (top_reg >= TW'(LINES))
                        begin
                            status_next = mlenv_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            wr_en        = 1'b1;
                            wr_addr      = PW'(top_reg);
                            wr_data      = {item.slope, item.intercept};
                            k_slope_next = item.slope;
                            k_icpt_next  = item.intercept;
                            top_next     = top_reg + TW'(1);
                            state_next   = S_ADD_CHK;
                        end
                    end
                    else
                    begin
                        if (top_reg == '0)
                        begin
                            status_next = mlenv_pkg::ST_EMPTY;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            qp_next    = qp_clamp;
                            rd_addr    = qp_clamp;
                            x_next     = item.x_value;
                            first_next = 1'b1;
                            state_next = S_Q_LOAD;
                        end
                    end
                end
            end

            S_ADD_CHK:
            begin
                if (top_reg >= TW'(3))
                begin
                    rd_addr    = PW'(top_reg - TW'(2));
                    state_next = S_ADD_RJ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_ADD_RJ:
            begin
                j_slope_next = rd_slope;
                j_icpt_next  = rd_icpt;
                rd_addr      = PW'(top_reg - TW'(3));
                state_next   = S_ADD_RI;
            end

            S_ADD_RI:
            begin
                // read data is line i now
                dik_next   = mlenv_pkg::DI_W'(k_icpt_reg) - mlenv_pkg::DI_W'(rd_icpt);
                dij_next   = mlenv_pkg::DI_W'(j_icpt_reg) - mlenv_pkg::DI_W'(rd_icpt);
                dsij_next  = mlenv_pkg::DS_W'(rd_slope) - mlenv_pkg::DS_W'(j_slope_reg);
                dsik_next  = mlenv_pkg::DS_W'(rd_slope) - mlenv_pkg::DS_W'(k_slope_reg);
                lhs_next   = '0;
                rhs_next   = '0;
                cnt_next   = '0;
                state_next = S_ADD_MUL;
            end

            S_ADD_MUL:
            begin
                // launch partial cnt, accumulate partial cnt-1
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mul_a = signed'({{(mlenv_pkg::MUL_W - mlenv_pkg::SPLIT){1'b0}},
                                         dik_reg[mlenv_pkg::SPLIT-1:0]});
                        mul_b = dsij_reg;
                    end
                    2'd1:
                    begin
                        mul_a = mlenv_pkg::MUL_W'(
                            signed'(dik_reg[mlenv_pkg::DI_W-1:mlenv_pkg::SPLIT]));
                        mul_b = dsij_reg;
                    end
                    2'd2:
                    begin
                        mul_a = signed'({{(mlenv_pkg::MUL_W - mlenv_pkg::SPLIT){1'b0}},
                                         dij_reg[mlenv_pkg::SPLIT-1:0]});
                        mul_b = dsik_reg;
                    end
                    default:
                    begin
                        mul_a = mlenv_pkg::MUL_W'(
                            signed'(dij_reg[mlenv_pkg::DI_W-1:mlenv_pkg::SPLIT]));
                        mul_b = dsik_reg;
                    end
                endcase
                if (cnt_reg != 3'd0)
                begin
                    if (!acc_idx[1])
                    begin
                        lhs_next = lhs_reg + acc_term;
                    end
                    else
                    begin
                        rhs_next = rhs_reg + acc_term;
                    end
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = S_ADD_CMP;
                end
            end

            S_ADD_CMP:
            begin
                if (redundant)
                begin
                    // new line moves down over the middle one
                    wr_en      = 1'b1;
                    wr_addr    = PW'(top_reg - TW'(2));
                    top_next   = top_reg - TW'(1);
                    state_next = S_ADD_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_Q_LOAD:
            begin
                qicpt_next = rd_icpt;
                state_next = S_Q_EVAL;
            end

            S_Q_EVAL:
            begin
                first_next = 1'b0;
                if (first_reg || advance)
                begin
                    cur_next = eval_val;
                    qp_next  = ptr_now;
                    if (TW'(ptr_now) + TW'(1) < top_reg)
                    begin
                        rd_addr    = PW'(ptr_now + PW'(1));
                        state_next = S_Q_LOAD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.min_value  = cur_reg;
                    result_next.status     = status_reg;
                    result_next.line_count = mlenv_pkg::COUNT_W'(top_reg);
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= line_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            top_reg          <= '0;
            qp_reg           <= '0;
            cnt_reg          <= '0;
            first_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            top_reg          <= top_next;
            qp_reg           <= qp_next;
            cnt_reg          <= cnt_next;
            first_reg        <= first_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_p;
        k_slope_reg <= k_slope_next;
        k_icpt_reg  <= k_icpt_next;
        j_slope_reg <= j_slope_next;
        j_icpt_reg  <= j_icpt_next;
        dik_reg     <= dik_next;
        dij_reg     <= dij_next;
        dsij_reg    <= dsij_next;
        dsik_reg    <= dsik_next;
        lhs_reg     <= lhs_next;
        rhs_reg     <= rhs_next;
        x_reg       <= x_next;
        qicpt_reg   <= qicpt_next;
        cur_reg     <= cur_next;
        status_reg  <= status_next;
        result_reg  <= result_next;
    end

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= TW'(LINES))
        else $error("stack top beyond store depth");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result word loaded outside completion");

    a_ptr_in_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_LOAD || state_reg == S_Q_EVAL) |-> TW'(qp_reg) < top_reg)
        else $error("query pointer past stack top");

    a_pop_needs_three: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_CMP && redundant) |=> top_reg >= TW'(2))
        else $error("pop left fewer than two lines");

endmodule

`default_nettype wire
